[src/stre_pkg.sv]
package stre_pkg;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_SP1   = 4'd1,
      PH_WDAY  = 4'd2,
      PH_SP2   = 4'd3,
      PH_MON   = 4'd4,
      PH_DAY   = 4'd5,
      PH_HOUR  = 4'd6,
      PH_COL1  = 4'd7,
      PH_MIN   = 4'd8,
      PH_COL2  = 4'd9,
      PH_SEC   = 4'd10,
      PH_YEAR  = 4'd11,
      PH_DONE  = 4'd12,
      PH_NOPFX = 4'd13
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DAYS,
      CS_YOE,
      CS_MUL1,
      CS_MUL2,
      CS_SUM,
      CS_OUT
   } conv_state_type;

   typedef struct packed {
      logic parse_en;
      logic start_conv;
      logic conv_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic last_seen;
   } status_type;

   localparam int unsigned PrefixLen = 13;

   function automatic logic [7:0] prefix_char(input logic [3:0] n);
      logic [7:0] c;
      unique case (n)
         4'd0:    c = 8'h2B;
         4'd1:    c = 8'h43;
         4'd2:    c = 8'h49;
         4'd3:    c = 8'h50;
         4'd4:    c = 8'h53;
         4'd5:    c = 8'h4E;
         4'd6:    c = 8'h54;
         4'd7:    c = 8'h50;
         4'd8:    c = 8'h54;
         4'd9:    c = 8'h49;
         4'd10:   c = 8'h4D;
         4'd11:   c = 8'h45;
         4'd12:   c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [23:0] month_text(input logic [3:0] i);
      logic [23:0] t;
      unique case (i)
         4'd0:    t = "Jan";
         4'd1:    t = "Feb";
         4'd2:    t = "Mar";
         4'd3:    t = "Apr";
         4'd4:    t = "May";
         4'd5:    t = "Jun";
         4'd6:    t = "Jul";
         4'd7:    t = "Aug";
         4'd8:    t = "Sep";
         4'd9:    t = "Oct";
         4'd10:   t = "Nov";
         default: t = "Dec";
      endcase
      return t;
   endfunction

   // day of year offset of month start, March based
   function automatic logic [8:0] month_doy(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         4'd12:   d = 9'd275;
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

[src/stre_if.sv]
interface stre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;
   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface stre_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;
   logic        time_valid;
   logic        prefix_found;
   modport source (output valid, output epoch_seconds, output time_valid,
                   output prefix_found, input ready);
   modport sink (input valid, input epoch_seconds, input time_valid,
                 input prefix_found, output ready);
endinterface

[src/stre_ctrl.sv]
module stre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stre_pkg::cmd_type   cmd,
   input  stre_pkg::status_type status
);

   stre_pkg::conv_state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic accept;
   logic finishing;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == stre_pkg::CS_IDLE);
   assign finishing = (state_ff == stre_pkg::CS_OUT) && !out_valid_ff;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stre_pkg::CS_IDLE: if (accept && req_last) state_in = stre_pkg::CS_DAYS;
         stre_pkg::CS_DAYS: state_in = stre_pkg::CS_YOE;
         stre_pkg::CS_YOE:  state_in = stre_pkg::CS_MUL1;
         stre_pkg::CS_MUL1: state_in = stre_pkg::CS_MUL2;
         stre_pkg::CS_MUL2: state_in = stre_pkg::CS_SUM;
         stre_pkg::CS_SUM:  state_in = stre_pkg::CS_OUT;
         stre_pkg::CS_OUT:  if (!out_valid_ff) state_in = stre_pkg::CS_IDLE;
         default:           state_in = stre_pkg::CS_IDLE;
      endcase
   end

   always_comb begin
      cmd.parse_en   = accept;
      cmd.start_conv = accept && req_last;
      cmd.conv_step  = (state_ff != stre_pkg::CS_IDLE) && (state_ff != stre_pkg::CS_OUT);
      cmd.load_out   = finishing;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (finishing) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stre_pkg::CS_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> state_ff == stre_pkg::CS_DAYS) else $error("conv not started");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != stre_pkg::CS_IDLE |-> !req_ready) else $error("accept while busy");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      finishing |=> out_valid_ff) else $error("result lost");
   a_status: assert property (@(posedge clock) disable iff (reset)
      state_ff == stre_pkg::CS_DAYS |-> status.last_seen) else $error("no last");

endmodule

[src/stre_dp.sv]
module stre_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_byte,
   input  logic                 last_byte,
   input  logic [15:0]          min_year,
   input  stre_pkg::cmd_type    cmd,
   output stre_pkg::status_type status,
   output logic [31:0]          epoch_seconds,
   output logic                 time_valid,
   output logic                 prefix_found
);

   stre_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  pcnt_ff, pcnt_in;
   logic [11:0] cand_ff, cand_in;
   logic [1:0]  mcnt_ff, mcnt_in;
   logic [3:0]  mon_ff, mon_in;
   logic [15:0] day_ff, day_in, hour_ff, hour_in, min_ff, min_in;
   logic [15:0] sec_ff, sec_in, year_ff, year_in;
   logic [4:0]  dseen_ff, dseen_in;
   logic        done_ff, done_in, fail_ff, fail_in;
   logic        last_ff;

   // parse step (at most two phases visited per byte)
   always_comb begin
      logic        is_digit;
      logic [3:0]  dv;
      logic [15:0] cur;
      logic [19:0] t;
      logic [15:0] nv;
      logic [2:0]  fb;
      logic        has;
      logic [11:0] nc;
      logic [3:0]  mn;
      stre_pkg::phase_type ph;
      logic        again;
      phase_in = phase_ff; pcnt_in = pcnt_ff; cand_in = cand_ff; mcnt_in = mcnt_ff;
      mon_in = mon_ff; day_in = day_ff; hour_in = hour_ff; min_in = min_ff;
      sec_in = sec_ff; year_in = year_ff; dseen_in = dseen_ff;
      done_in = done_ff; fail_in = fail_ff;
      is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
      dv = rx_byte[3:0];
      nc = cand_ff; mn = 4'd0;
      cur = 16'd0; t = 20'd0; nv = 16'd0; fb = 3'd0; has = 1'b0;
      ph = phase_ff; again = 1'b0;
      if (phase_ff != stre_pkg::PH_DONE && phase_ff != stre_pkg::PH_NOPFX) begin
         if (rx_byte == 8'h00) begin
            if (phase_ff == stre_pkg::PH_HUNT) phase_in = stre_pkg::PH_NOPFX;
            else again = 1'b1;
         end else begin
            if (phase_ff == stre_pkg::PH_SP2 && rx_byte != 8'h20) ph = stre_pkg::PH_MON;
            // number field that ends on a non-digit moves to the next phase
            if (phase_ff >= stre_pkg::PH_DAY && phase_ff <= stre_pkg::PH_SEC
                && phase_ff != stre_pkg::PH_COL1 && phase_ff != stre_pkg::PH_COL2
                && !is_digit) begin
               unique case (phase_ff)
                  stre_pkg::PH_DAY:  has = dseen_ff[0];
                  stre_pkg::PH_HOUR: has = dseen_ff[1];
                  stre_pkg::PH_MIN:  has = dseen_ff[2];
                  default:           has = dseen_ff[3];
               endcase
               if (has) ph = stre_pkg::phase_type'(phase_ff + 4'd1);
            end
            unique case (ph)
               stre_pkg::PH_HUNT: begin
                  if (rx_byte == stre_pkg::prefix_char(pcnt_ff)) pcnt_in = pcnt_ff + 4'd1;
                  else pcnt_in = (rx_byte == 8'h2B) ? 4'd1 : 4'd0;
                  if (pcnt_in == 4'(stre_pkg::PrefixLen)) phase_in = stre_pkg::PH_SP1;
               end
               stre_pkg::PH_SP1:  if (rx_byte != 8'h20) phase_in = stre_pkg::PH_WDAY;
               stre_pkg::PH_WDAY: if (rx_byte == 8'h20) phase_in = stre_pkg::PH_SP2;
               stre_pkg::PH_SP2:  phase_in = stre_pkg::PH_SP2;
               stre_pkg::PH_MON: begin
                  phase_in = stre_pkg::PH_MON;
                  for (int i = 0; i < 12; i++) begin
                     logic [23:0] mt;
                     mt = stre_pkg::month_text(4'(i));
                     unique case (mcnt_ff)
                        2'd0:    if (mt[23:16] != rx_byte) nc[i] = 1'b0;
                        2'd1:    if (mt[15:8] != rx_byte) nc[i] = 1'b0;
                        default: if (mt[7:0] != rx_byte) nc[i] = 1'b0;
                     endcase
                  end
                  for (int i = 11; i >= 0; i--) if (nc[i]) mn = 4'(i + 1);
                  cand_in = nc;
                  mcnt_in = mcnt_ff + 2'd1;
                  if (mcnt_ff == 2'd3) begin
                     fail_in = 1'b1; phase_in = stre_pkg::PH_DONE;
                     mcnt_in = mcnt_ff; cand_in = cand_ff;
                  end else if (mcnt_ff == 2'd2) begin
                     mon_in = mn;
                     if (mn == 4'd0) begin
                        fail_in = 1'b1; phase_in = stre_pkg::PH_DONE;
                     end else phase_in = stre_pkg::PH_DAY;
                  end
               end
               stre_pkg::PH_COL1, stre_pkg::PH_COL2: begin
                  if (rx_byte == 8'h3A) phase_in = stre_pkg::phase_type'(ph + 4'd1);
                  else begin
                     fail_in = 1'b1; phase_in = stre_pkg::PH_DONE;
                  end
               end
               stre_pkg::PH_DAY, stre_pkg::PH_HOUR, stre_pkg::PH_MIN,
               stre_pkg::PH_SEC, stre_pkg::PH_YEAR: begin
                  unique case (ph)
                     stre_pkg::PH_DAY:  begin cur = day_ff;  fb = 3'd0; end
                     stre_pkg::PH_HOUR: begin cur = hour_ff; fb = 3'd1; end
                     stre_pkg::PH_MIN:  begin cur = min_ff;  fb = 3'd2; end
                     stre_pkg::PH_SEC:  begin cur = sec_ff;  fb = 3'd3; end
                     default:           begin cur = year_ff; fb = 3'd4; end
                  endcase
                  has = dseen_ff[fb];
                  phase_in = ph;
                  if (is_digit) begin
                     t = {cur, 3'b000} + {3'b000, cur, 1'b0} + {16'd0, dv};
                     nv = (t > 20'd65535) ? 16'hFFFF : t[15:0];
                     dseen_in[fb] = 1'b1;
                     unique case (ph)
                        stre_pkg::PH_DAY:  day_in  = nv;
                        stre_pkg::PH_HOUR: hour_in = nv;
                        stre_pkg::PH_MIN:  min_in  = nv;
                        stre_pkg::PH_SEC:  sec_in  = nv;
                        default:           year_in = nv;
                     endcase
                  end else if (rx_byte == 8'h20 && !has) begin
                     phase_in = ph;
                  end else if (!has) begin
                     fail_in = 1'b1; phase_in = stre_pkg::PH_DONE;
                  end else begin
                     done_in = 1'b1; phase_in = stre_pkg::PH_DONE;
                  end
               end
               default: phase_in = ph;
            endcase
         end
      end
      // end of text: zero byte or last byte
      if (again || (last_byte && phase_in != stre_pkg::PH_HUNT
                    && phase_in != stre_pkg::PH_DONE && phase_in != stre_pkg::PH_NOPFX)) begin
         if (!again || (phase_ff != stre_pkg::PH_HUNT)) begin
            if (phase_in == stre_pkg::PH_YEAR && dseen_in[4]) done_in = 1'b1;
            else fail_in = 1'b1;
            phase_in = stre_pkg::PH_DONE;
         end
      end
   end

   // conversion datapath
   logic        valid_ff, found_ff;
   logic [16:0] y_ff;
   logic [8:0]  doy_ff;
   logic [8:0]  era_ff;
   logic [8:0]  yoe_ff;
   logic [31:0] days_ff, tod_a_ff, tod_b_ff, acc_ff;
   logic [31:0] eout_ff;
   logic        vout_ff, fout_ff;
   logic [2:0]  cstep_ff;

   always_comb begin
      status.last_seen = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= stre_pkg::PH_HUNT; pcnt_ff <= '0; cand_ff <= '1; mcnt_ff <= '0;
         mon_ff <= '0; day_ff <= '0; hour_ff <= '0; min_ff <= '0; sec_ff <= '0;
         year_ff <= '0; dseen_ff <= '0; done_ff <= 1'b0; fail_ff <= 1'b0;
         last_ff <= 1'b0; cstep_ff <= '0;
      end else begin
         if (cmd.parse_en) last_ff <= last_byte;
         if (cmd.start_conv) begin
            phase_ff <= stre_pkg::PH_HUNT; pcnt_ff <= '0; cand_ff <= '1; mcnt_ff <= '0;
            mon_ff <= '0; day_ff <= '0; hour_ff <= '0; min_ff <= '0; sec_ff <= '0;
            year_ff <= '0; dseen_ff <= '0; done_ff <= 1'b0; fail_ff <= 1'b0;
         end else if (cmd.parse_en) begin
            phase_ff <= phase_in; pcnt_ff <= pcnt_in; cand_ff <= cand_in;
            mcnt_ff <= mcnt_in; mon_ff <= mon_in; day_ff <= day_in; hour_ff <= hour_in;
            min_ff <= min_in; sec_ff <= sec_in; year_ff <= year_in;
            dseen_ff <= dseen_in; done_ff <= done_in; fail_ff <= fail_in;
         end
         if (cmd.start_conv) cstep_ff <= 3'd0;
         else if (cmd.conv_step) cstep_ff <= cstep_ff + 3'd1;
      end
   end

   // capture snapshot on last beat, then compute over the conversion steps
   logic [15:0] cday_ff, chour_ff, cmin_ff, csec_ff;
   logic [16:0] yadj;
   logic [31:0] era_days, yoe_days;
   logic [23:0] era_prod;
   logic [15:0] era_x400, yoe_diff;
   logic [31:0] yoe_cent;

   assign yadj = {1'b0, year_in} - ((mon_in <= 4'd2) ? 17'd1 : 17'd0);

   always_ff @(posedge clock) begin
      if (cmd.start_conv) begin
         found_ff <= (phase_in >= stre_pkg::PH_SP1) && (phase_in <= stre_pkg::PH_DONE);
         valid_ff <= (phase_in >= stre_pkg::PH_SP1) && (phase_in <= stre_pkg::PH_DONE)
                     && done_in && !fail_in && mon_in >= 4'd1 && mon_in <= 4'd12
                     && day_in >= 16'd1 && year_in >= min_year;
         y_ff     <= yadj;
         doy_ff   <= stre_pkg::month_doy(mon_in);
         cday_ff  <= day_in; chour_ff <= hour_in; cmin_ff <= min_in; csec_ff <= sec_in;
      end
      if (cmd.conv_step) begin
         unique case (cstep_ff)
            3'd0: begin
               // y = -1 only for year 0 Jan/Feb: floored era -1, yoe 399
               if (y_ff[16]) era_ff <= 9'h1FF;
               else era_ff <= {1'b0, era_prod[23:16]};
            end
            3'd1: begin
               if (y_ff[16]) yoe_ff <= 9'd399;
               else yoe_ff <= yoe_diff[8:0];
            end
            3'd2: begin
               days_ff  <= era_days + yoe_days;
               tod_a_ff <= {16'd0, chour_ff} * 32'd3600;
            end
            3'd3: begin
               days_ff  <= days_ff + 32'(doy_ff) + 32'(cday_ff) - 32'd1 - 32'd719468;
               tod_b_ff <= {16'd0, cmin_ff} * 32'd60 + 32'(csec_ff);
            end
            default: begin
               acc_ff <= days_ff * 32'd86400 + tod_a_ff + tod_b_ff;
            end
         endcase
      end
      if (cmd.load_out) begin
         eout_ff <= valid_ff ? acc_ff : 32'd0;
         vout_ff <= valid_ff;
         fout_ff <= found_ff;
      end
   end

   // y / 400 as (y >> 4) / 25 by reciprocal, exact for y below 2^16
   assign era_prod = {12'd0, y_ff[15:4]} * 24'd2622;
   assign era_x400 = {8'd0, era_ff[7:0]} * 16'd400;
   assign yoe_diff = y_ff[15:0] - era_x400;
   assign yoe_cent = (yoe_ff >= 9'd300) ? 32'd3 :
                     (yoe_ff >= 9'd200) ? 32'd2 :
                     (yoe_ff >= 9'd100) ? 32'd1 : 32'd0;

   assign era_days = {{23{era_ff[8]}}, era_ff} * 32'd146097;
   assign yoe_days = 32'(yoe_ff) * 32'd365 + 32'(yoe_ff >> 2) - yoe_cent;

   assign epoch_seconds = eout_ff;
   assign time_valid    = vout_ff;
   assign prefix_found  = fout_ff;

   a_valid_found: assert property (@(posedge clock) disable iff (reset)
      vout_ff |-> fout_ff) else $error("valid without prefix");
   a_zero_invalid: assert property (@(posedge clock) disable iff (reset)
      !vout_ff && $past(cmd.load_out) |-> eout_ff == 32'd0) else $error("nonzero epoch");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.start_conv |=> phase_ff == stre_pkg::PH_HUNT) else $error("parse not cleared");

endmodule

[src/sntp_time_reply_to_epoch.sv]
// SNTP time reply parser.
// req: one reply byte per beat (rx_byte, last_byte). The parser hunts for
// "+CIPSNTPTIME:", then reads weekday, month, day, hh:mm:ss and year.
// rsp: one beat per buffer, after the byte marked last_byte, carrying the Unix
// epoch_seconds, time_valid and prefix_found.
// csr: csr_we/csr_wdata write min_valid_year (reset 2024); write while idle.
// Throughput: one byte per cycle while parsing. The last byte starts a
// civil-date conversion (era, year of era, day count, seconds); req_ready
// is low until it ends, and longer if the previous result beat still
// waits on rsp_ready.
// The result beat rises after the conversion states DAYS, YOE, MUL1, MUL2,
// SUM and OUT, when no earlier result is pending.
// Reset (synchronous, active high) clears the parser, drops rsp_valid and
// restores min_valid_year. A stalled receiver holds the result beat stable;
// bytes of the next buffer are still taken, and its conversion holds in the
// OUT state until the waiting beat is taken.
module sntp_time_reply_to_epoch (
   input  logic        clock,
   input  logic        reset,
   stre_req_if.sink    req,
   stre_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0] min_year_ff;
   stre_pkg::cmd_type    cmd;
   stre_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) min_year_ff <= 16'd2024;
      else if (csr_we) min_year_ff <= csr_wdata;
   end

   stre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_byte),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   stre_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req.rx_byte),
      .last_byte     (req.last_byte),
      .min_year      (min_year_ff),
      .cmd           (cmd),
      .status        (status),
      .epoch_seconds (rsp.epoch_seconds),
      .time_valid    (rsp.time_valid),
      .prefix_found  (rsp.prefix_found)
   );

endmodule

[sim/tb.sv]
module tb;

   class epoch_board;
      logic [31:0] exp_epoch[$];
      logic        exp_valid[$];
      logic        exp_found[$];
      int          errors = 0;

      logic [15:0] min_year = 16'd2024;
      stre_pkg::phase_type ph;
      logic [3:0]  pfx_n;
      logic [11:0] cand;
      logic [1:0]  mcnt;
      logic [3:0]  mon;
      logic [15:0] val[5];
      logic [4:0]  seen;
      logic        done_f, fail_f;

      function new();
         clear();
      endfunction

      function void clear();
         ph = stre_pkg::PH_HUNT; pfx_n = 0; cand = 12'hFFF; mcnt = 0; mon = 0;
         foreach (val[i]) val[i] = 0;
         seen = 0; done_f = 0; fail_f = 0;
      endfunction

      function void fail_now();
         fail_f = 1; ph = stre_pkg::PH_DONE;
      endfunction

      function void end_text();
         if (ph == stre_pkg::PH_HUNT || ph >= stre_pkg::PH_DONE) return;
         if (ph == stre_pkg::PH_YEAR && seen[4]) begin
            done_f = 1; ph = stre_pkg::PH_DONE;
         end else fail_now();
      endfunction

      function void take(logic [7:0] c);
         int k, b;
         logic [23:0] t;
         logic [31:0] acc;
         if (c == 0) begin
            if (ph == stre_pkg::PH_HUNT) ph = stre_pkg::PH_NOPFX;
            else end_text();
            return;
         end
         for (int g = 0; g < 8; g++) begin
            case (ph)
               stre_pkg::PH_HUNT: begin
                  if (pfx_n < stre_pkg::PrefixLen && c == stre_pkg::prefix_char(pfx_n))
                     pfx_n++;
                  else pfx_n = (c == "+") ? 4'd1 : 4'd0;
                  if (pfx_n >= stre_pkg::PrefixLen) ph = stre_pkg::PH_SP1;
                  return;
               end
               stre_pkg::PH_SP1: begin
                  if (c != " ") ph = stre_pkg::PH_WDAY;
                  return;
               end
               stre_pkg::PH_WDAY: begin
                  if (c == " ") ph = stre_pkg::PH_SP2;
                  return;
               end
               stre_pkg::PH_SP2: begin
                  if (c == " ") return;
                  ph = stre_pkg::PH_MON;
               end
               stre_pkg::PH_MON: begin
                  k = mcnt;
                  if (k > 2) begin fail_now(); return; end
                  for (int i = 0; i < 12; i++) begin
                     t = stre_pkg::month_text(4'(i));
                     if (t[23-8*k -: 8] != c) cand[i] = 0;
                  end
                  mcnt = 2'(k + 1);
                  if (k == 2) begin
                     mon = 0;
                     for (int i = 11; i >= 0; i--) if (cand[i]) mon = 4'(i + 1);
                     if (mon == 0) fail_now();
                     else ph = stre_pkg::PH_DAY;
                  end
                  return;
               end
               stre_pkg::PH_COL1, stre_pkg::PH_COL2: begin
                  if (c == ":") ph = stre_pkg::phase_type'(ph + 1);
                  else fail_now();
                  return;
               end
               stre_pkg::PH_DAY, stre_pkg::PH_HOUR, stre_pkg::PH_MIN, stre_pkg::PH_SEC,
               stre_pkg::PH_YEAR: begin
                  b = (ph == stre_pkg::PH_DAY) ? 0 : (ph == stre_pkg::PH_HOUR) ? 1 :
                      (ph == stre_pkg::PH_MIN) ? 2 : (ph == stre_pkg::PH_SEC) ? 3 : 4;
                  if (c >= "0" && c <= "9") begin
                     acc = val[b] * 10 + (c - "0");
                     val[b] = (acc > 65535) ? 16'hFFFF : acc[15:0];
                     seen[b] = 1;
                     return;
                  end
                  if (c == " " && !seen[b]) return;
                  if (!seen[b]) begin fail_now(); return; end
                  if (ph == stre_pkg::PH_YEAR) begin
                     done_f = 1; ph = stre_pkg::PH_DONE; return;
                  end
                  ph = stre_pkg::phase_type'(ph + 1);
               end
               default: return;
            endcase
         end
      endfunction

      function logic [31:0] civil();
         longint y, m, era, yoe, doy, doe, days, secs;
         y = val[4]; m = mon;
         if (m <= 2) y -= 1;
         era = (y >= 0 ? y : y - 399) / 400;
         yoe = y - era * 400;
         doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + val[0] - 1;
         doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         days = era * 146097 + doe - 719468;
         secs = days * 86400 + longint'(val[1]) * 3600 + longint'(val[2]) * 60
              + val[3];
         return secs[31:0];
      endfunction

      function void note_byte(logic [7:0] c, logic last);
         logic found, ok;
         if (ph != stre_pkg::PH_DONE && ph != stre_pkg::PH_NOPFX) take(c);
         if (!last) return;
         end_text();
         found = ph >= stre_pkg::PH_SP1 && ph <= stre_pkg::PH_DONE;
         ok = found && done_f && !fail_f && mon >= 1 && mon <= 12 && val[0] >= 1
              && val[4] >= min_year;
         exp_epoch.push_back(ok ? civil() : 32'd0);
         exp_valid.push_back(ok);
         exp_found.push_back(found);
         clear();
      endfunction

      function int pending();
         return exp_epoch.size();
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check(logic [31:0] e, logic v, logic f);
         logic [31:0] xe;
         logic xv, xf;
         if (exp_epoch.size() == 0) begin
            report($sformatf("unexpected beat epoch=%0d", e));
            return;
         end
         xe = exp_epoch.pop_front(); xv = exp_valid.pop_front();
         xf = exp_found.pop_front();
         if (e !== xe) report($sformatf("epoch %0d want %0d", e, xe));
         if (v !== xv) report($sformatf("time_valid %b want %b", v, xv));
         if (f !== xf) report($sformatf("prefix_found %b want %b", f, xf));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [15:0] csr_wdata = 0;
   stre_req_if req();
   stre_rsp_if rsp();
   epoch_board sb = new();
   int cycles = 0;
   int n_sent = 0;
   bit stim_done = 0;

   sntp_time_reply_to_epoch uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      req.valid = 0; req.rx_byte = 0; req.last_byte = 0; rsp.ready = 0;
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("tb: errors");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready)
         sb.check(rsp.epoch_seconds, rsp.time_valid, rsp.prefix_found);
   end

   initial begin
      int g;
      @(negedge clock);
      while (!stim_done || sb.pending() != 0) begin
         g = gap_len();
         if (g > 0) begin
            rsp.ready <= 0;
            repeat (g) @(negedge clock);
         end
         rsp.ready <= 1;
         @(negedge clock);
      end
      rsp.ready <= 1;
   end

   task send(logic [7:0] c, logic last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(negedge clock);
      end
      req.valid <= 1; req.rx_byte <= c; req.last_byte <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_byte(c, last);
      n_sent++;
      @(negedge clock);
   endtask

   task send_str(string s, logic end_it);
      for (int i = 0; i < s.len(); i++) send(s[i], end_it && i == s.len() - 1);
   endtask

   task drain();
      req.valid <= 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task set_min(logic [15:0] y);
      drain();
      csr_we <= 1; csr_wdata <= y;
      sb.min_year = y;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function string num(int v, int w);
      string s;
      s = $sformatf("%0d", v);
      while (s.len() < w) s = {"0", s};
      return s;
   endfunction

   function string pick_month();
      logic [23:0] t;
      t = stre_pkg::month_text(4'($urandom_range(0, 11)));
      return $sformatf("%s", t);
   endfunction

   task random_reply();
      string s, sp;
      int r;
      r = $urandom_range(0, 99);
      sp = ($urandom_range(0, 3) == 0) ? "  " : " ";
      if (r < 10) begin
         for (int i = 0; i < $urandom_range(1, 6); i++) send(8'($urandom), 0);
      end
      s = {"+CIPSNTPTIME:", sp, "Thu", sp, pick_month(), sp,
           num($urandom_range(0, 31), $urandom_range(1, 2)), " ",
           num($urandom_range(0, 25), 2), ":", num($urandom_range(0, 61), 2), ":",
           num($urandom_range(0, 61), 2), sp, num($urandom_range(1965, 2110), 4)};
      if (r >= 70 && r < 85) begin
         int p;
         p = $urandom_range(0, s.len() - 1);
         s[p] = 8'($urandom);
      end
      if (r >= 85 && r < 92) s = s.substr(0, $urandom_range(0, s.len() - 1));
      if (r >= 92) begin
         for (int i = 0; i < $urandom_range(1, 8); i++) send(8'($urandom), 0);
         send(8'($urandom), 1);
         return;
      end
      if ($urandom_range(0, 1)) begin
         send_str(s, 0);
         send_str("\r\nOK", 0);
         send($urandom_range(0, 1) ? 8'h0A : 8'h00, 1);
      end else send_str(s, 1);
   endtask

   initial begin
      int replies;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_str("+CIPSNTPTIME:Thu Aug 13 05:26:00 2026", 1);
      send_str("++CIPSNTPTIME:Sun Jan 1 0:0:0 2024x", 1);
      send_str("+CIPSNTPTIME:Mon Feb  29 23:59:59   2024", 1);
      send_str("+CIPSNTPTIME:Wed jan 1 00:00:00 2030", 1);
      send_str("+CIPSNTPTIME:Wed Dec 0 00:00:00 2030", 1);
      send_str("+CIPSNTPTIME:Wed Dec 31 99999:99:99 2030", 1);
      send_str("+CIPSNTPTIME:Wed Dec 31 12-00:00 2030", 1);
      send_str("+CIPSNTPTIME:Thu Jan 1 00:00:00 1970", 1);
      send_str("+CIPSNTPTIME:Thu Mar 5 1:2:3 ", 1);
      send(8'hFF, 1);
      send_str("+CIPSNTPTIME:Thu Mar 5 1:2:3 2050", 0);
      send(8'h00, 0); send_str("99", 1);
      set_min(16'd0);
      send_str("+CIPSNTPTIME:Thu Jan 1 00:00:00 0", 1);
      send_str("+CIPSNTPTIME:Thu Jan 1 00:00:00 1969", 1);
      set_min(16'hFFFF);
      send_str("+CIPSNTPTIME:Thu Jan 1 00:00:00 65535", 1);
      send_str("+CIPSNTPTIME:Thu Jul 9 00:00:00 999999", 1);
      set_min(16'd1);
      replies = 0;
      while (n_sent < 850) begin
         if (replies == 2) set_min(16'd2000);
         if (replies == 4) drain();
         if (replies == 6) set_min(16'd2024);
         random_reply();
         replies++;
      end
      stim_done = 1;
      drain();
      if (sb.errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
